// ----- src/btg_pkg.sv -----
// ----------------------------------------------------------------------------
// btg_pkg
// Types, sequencer op codes and fixed constants shared by the gauge modules.
// ----------------------------------------------------------------------------
package btg_pkg;

	localparam int IN_W  = 64;
	localparam int OUT_W = 80;

	// sequencer ops, one per work cycle
	localparam logic [3:0] OP_VB_SCALE  = 4'd0;
	localparam logic [3:0] OP_VB_RECIP  = 4'd1;
	localparam logic [3:0] OP_OC_SCALE  = 4'd2;
	localparam logic [3:0] OP_OC_RECIP  = 4'd3;
	localparam logic [3:0] OP_CUR_SCALE = 4'd4;
	localparam logic [3:0] OP_CUR_RECIP = 4'd5;
	localparam logic [3:0] OP_SOC_SCALE = 4'd6;
	localparam logic [3:0] OP_SEG       = 4'd7;
	localparam logic [3:0] OP_DIV3      = 4'd8;
	localparam logic [3:0] OP_DIV2      = 4'd9;
	localparam logic [3:0] OP_DIV1      = 4'd10;
	localparam logic [3:0] OP_DIV0      = 4'd11;

	// led event codes
	localparam logic [1:0] LED_NONE  = 2'd0;
	localparam logic [1:0] LED_SOLID = 2'd1;
	localparam logic [1:0] LED_BLINK = 2'd2;

	localparam logic [2:0] FULL_CODE_RESET = 3'd5;
	localparam logic [3:0] NO_STATE        = 4'd9;

	// voltage: code * 42968 / 625 = code * 68 + code * 468 / 625
	localparam logic [20:0] VOLT_BASE_Q8 = 21'd665600;
	localparam logic [20:0] VOLT_INT     = 21'd68;
	localparam logic [25:0] VOLT_FRAC    = 26'd468;
	localparam logic [25:0] VOLT_RECIP   = 26'd13743896;
	localparam int          VOLT_SHIFT   = 33;

	// current: mag * 596788 / 3125 = mag * 190 + mag * 3038 / 3125
	localparam logic [20:0] CUR_INT   = 21'd190;
	localparam logic [25:0] CUR_FRAC  = 26'd3038;
	localparam logic [25:0] CUR_RECIP = 26'd43980466;
	localparam int          CUR_SHIFT = 37;
	localparam logic [13:0] CUR_WRAP  = 14'd8192;

	// ocv above 2600 mV in units of 1e-5 mV
	localparam logic [25:0] OCV_STEP = 26'd26855;
	localparam logic [6:0]  PCT_FULL = 7'd100;
	localparam logic [6:0]  PCT_EMPTY = 7'd0;

	localparam logic [28:0] OCV_THR [11] = '{
		29'd155000000, 29'd145000000, 29'd135000000, 29'd127000000,
		29'd122000000, 29'd118000000, 29'd114000000, 29'd108000000,
		29'd100000000, 29'd85000000,  29'd60000000
	};

	// segment width divided by ten
	localparam logic [21:0] SEG_DEN [10] = '{
		22'd1000000, 22'd1000000, 22'd800000, 22'd500000, 22'd400000,
		22'd400000,  22'd600000,  22'd800000, 22'd1500000, 22'd2500000
	};

	localparam logic [6:0] SEG_PCT_LO [10] = '{
		7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10, 7'd0
	};

	typedef struct packed {
		logic       load;
		logic       run;
		logic [3:0] op;
		logic       publish;
	} btg_cmd_t;

endpackage

// ----- src/btg_ctrl.sv -----
// ----------------------------------------------------------------------------
// btg_ctrl
// Sequencer: accepts an item, steps the datapath ops and publishes the result.
// ----------------------------------------------------------------------------
module btg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output btg_pkg::btg_cmd_t cmd
);
	import btg_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0] state_q;
	logic [3:0] op_q;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd.load    = in_valid && (state_q == ST_IDLE);
		cmd.run     = (state_q == ST_RUN);
		cmd.op      = op_q;
		cmd.publish = (state_q == ST_HOLD) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_VB_SCALE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						op_q    <= OP_VB_SCALE;
					end
				end
				ST_RUN: begin
					if (op_q == OP_DIV0) begin
						state_q <= ST_HOLD;
					end else begin
						op_q <= op_q + 4'd1;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/btg_dp.sv -----
// ----------------------------------------------------------------------------
// btg_dp
// Datapath: shared multiplier, reciprocal scaling, segment search,
// four-step quotient divider, charge state tracking and output register.
// ----------------------------------------------------------------------------
module btg_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  btg_pkg::btg_cmd_t         cmd,
	input  logic [btg_pkg::IN_W-1:0]  in_data,
	input  logic                      cfg_we,
	input  logic [2:0]                cfg_data,
	output logic [btg_pkg::OUT_W-1:0] out_data
);
	import btg_pkg::*;

	logic [13:0] vb_q;
	logic [13:0] oc_q;
	logic [13:0] mag_q;
	logic        neg_q;
	logic [2:0]  chg_q;
	logic        vbus_q;
	logic [51:0] p_q;
	logic [20:0] bat_q;
	logic [20:0] ocv_q;
	logic [21:0] cur_q;
	logic [6:0]  base_q;
	logic [24:0] rem_q;
	logic [21:0] den_q;
	logic [3:0]  quo_q;
	logic [2:0]  full_q;
	logic [3:0]  last_q;
	logic [OUT_W-1:0] out_q;

	logic [12:0] code13;
	logic [25:0] mul_a;
	logic [25:0] mul_b;
	logic [28:0] ocv_rel;
	logic [3:0]  seg;
	logic [1:0]  div_sh;
	logic [24:0] trial;
	logic [20:0] cur_mag;
	logic        chg_new;
	logic        is_full;
	logic [6:0]  pct;
	logic [1:0]  led;

	assign code13 = {in_data[44:40], in_data[39:32]};
	assign ocv_rel = p_q[28:0];
	assign div_sh  = 2'(OP_DIV0 - cmd.op);
	assign trial   = {3'b000, den_q} << div_sh;
	assign cur_mag = (21'(mag_q) * CUR_INT) + 21'(p_q[CUR_SHIFT +: 14]);
	assign is_full = (chg_q == full_q);
	assign chg_new = vbus_q && ({1'b0, chg_q} != last_q);
	assign pct     = is_full ? PCT_FULL : (base_q + {3'b000, quo_q});
	assign led     = chg_new ? (is_full ? LED_SOLID : LED_BLINK) : LED_NONE;
	assign out_data = out_q;

	always_comb begin
		case (cmd.op)
			OP_VB_SCALE: begin
				mul_a = 26'(vb_q);
				mul_b = VOLT_FRAC;
			end
			OP_VB_RECIP, OP_OC_RECIP: begin
				mul_a = 26'(p_q[22:0]);
				mul_b = VOLT_RECIP;
			end
			OP_OC_SCALE: begin
				mul_a = 26'(oc_q);
				mul_b = VOLT_FRAC;
			end
			OP_CUR_SCALE: begin
				mul_a = 26'(mag_q);
				mul_b = CUR_FRAC;
			end
			OP_CUR_RECIP: begin
				mul_a = 26'(p_q[24:0]);
				mul_b = CUR_RECIP;
			end
			OP_SOC_SCALE: begin
				mul_a = 26'(oc_q);
				mul_b = OCV_STEP;
			end
			default: begin
				mul_a = 26'd0;
				mul_b = 26'd0;
			end
		endcase
	end

	always_comb begin
		seg = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if ((ocv_rel > OCV_THR[i+1]) && (ocv_rel <= OCV_THR[i])) begin
				seg = 4'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= FULL_CODE_RESET;
			last_q <= NO_STATE;
		end else begin
			if (cfg_we) begin
				full_q <= cfg_data;
			end
			if (cmd.publish && chg_new) begin
				last_q <= {1'b0, chg_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			vb_q   <= {in_data[13:8], in_data[7:0]};
			oc_q   <= {in_data[29:24], in_data[23:16]};
			neg_q  <= in_data[45];
			mag_q  <= in_data[45] ? (CUR_WRAP - {1'b0, code13}) : {1'b0, code13};
			chg_q  <= in_data[55:53];
			vbus_q <= in_data[56];
		end
		if (cmd.run) begin
			p_q <= mul_a * mul_b;
			case (cmd.op)
				OP_OC_SCALE: begin
					bat_q <= VOLT_BASE_Q8 + (21'(vb_q) * VOLT_INT)
						+ 21'(p_q[VOLT_SHIFT +: 14]);
				end
				OP_CUR_SCALE: begin
					ocv_q <= VOLT_BASE_Q8 + (21'(oc_q) * VOLT_INT)
						+ 21'(p_q[VOLT_SHIFT +: 14]);
				end
				OP_SOC_SCALE: begin
					cur_q <= neg_q ? (22'd0 - {1'b0, cur_mag}) : {1'b0, cur_mag};
				end
				OP_SEG: begin
					quo_q <= 4'd0;
					den_q <= SEG_DEN[seg];
					if (ocv_rel >= OCV_THR[0]) begin
						base_q <= PCT_FULL;
						rem_q  <= 25'd0;
					end else if (ocv_rel <= OCV_THR[10]) begin
						base_q <= PCT_EMPTY;
						rem_q  <= 25'd0;
					end else begin
						base_q <= SEG_PCT_LO[seg];
						rem_q  <= 25'(ocv_rel - OCV_THR[seg + 4'd1]);
					end
				end
				OP_DIV3, OP_DIV2, OP_DIV1, OP_DIV0: begin
					if (rem_q >= trial) begin
						rem_q          <= rem_q - trial;
						quo_q[div_sh]  <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.publish) begin
			out_q <= {7'd0, led, pct, cur_q, ocv_q, bat_q};
		end
	end

endmodule

// ----- src/battery_telemetry_gauge.sv -----
// ----------------------------------------------------------------------------
// battery_telemetry_gauge
// Fuel gauge for one charger telemetry poll: battery and open-circuit voltage,
// signed current, charge percentage from an open-circuit-voltage curve and
// an LED event on a charger state change.
// ----------------------------------------------------------------------------
// Each item is worked on alone: an accept cycle, twelve ops of a sequencer
// that drives one shared 26x26 multiplier (scaling and reciprocal steps for
// both voltages, the current and the ocv), a segment search and a four-step
// quotient divider for the interpolation, and a publish cycle. The output
// register lets the next item enter while a result waits; if the result is
// still not taken when the next one is done, the block waits.
// The full-state code is written on the cfg channel, which is always ready.
module battery_telemetry_gauge (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// vbat_low_byte, vbat_high_byte, ocv_low_byte, ocv_high_byte,
	// current_low_byte, current_high_byte, status_byte, vbus_present
	input  logic [63:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// battery_mv_q8, open_circuit_mv_q8, current_ma_q8, charge_percent,
	// led_event
	output logic [79:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data
);
	import btg_pkg::*;

	btg_cmd_t cmd;

	assign cfg_ready = 1'b1;

	btg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	btg_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (s_axis_tdata),
		.cfg_we   (cfg_valid),
		.cfg_data (cfg_data),
		.out_data (m_axis_tdata)
	);

endmodule

// ----- dv/tb_battery_telemetry_gauge.sv -----
// ----------------------------------------------------------------------------
// tb_battery_telemetry_gauge
// Self-checking bench for the battery gauge. Telemetry polls stream in from a
// queue while an in-bench model works out voltages, current, charge percent
// and LED event for each accepted poll. Results are compared field by field,
// in order, under random gaps on both sides and several full-state codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_battery_telemetry_gauge;

	localparam int SETTLE_CYCLES  = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_POLLS    = 160;

	localparam longint unsigned CURVE_MV [11] = '{
		4150, 4050, 3950, 3870, 3820, 3780, 3740, 3680, 3600, 3450, 3200
	};

	typedef struct packed {
		logic       vbus;
		logic [7:0] status_byte;
		logic [7:0] cur_hi;
		logic [7:0] cur_lo;
		logic [7:0] ocv_hi;
		logic [7:0] ocv_lo;
		logic [7:0] vbat_hi;
		logic [7:0] vbat_lo;
	} poll_t;

	typedef struct packed {
		logic [1:0]         led;
		logic [6:0]         pct;
		logic signed [21:0] cur;
		logic [20:0]        ocv_mv;
		logic [20:0]        vbat_mv;
	} gauge_reading_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_data = '0;

	poll_t          polls_to_send [$];
	gauge_reading_t gauge_readings [$];

	logic [2:0] full_code = btg_pkg::FULL_CODE_RESET;
	logic [3:0] last_state = btg_pkg::NO_STATE;
	int         errors = 0;
	int         idle_cycles = 0;
	int         send_gap = 0;
	int         recv_stall = 0;
	bit         send_calm = 1'b0;
	bit         recv_calm = 1'b0;
	logic [2:0] prev_rand_state = '0;

	battery_telemetry_gauge dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [20:0] mv_q8(logic [13:0] code);
		longint unsigned scaled;
		scaled = 64'(code) * 64'd6874880 / 64'd100000;
		return 21'(64'd665600 + scaled);
	endfunction

	// ocv held in units of 1e-5 mV so the curve compare is exact
	function automatic logic [6:0] ocv_percent(logic [13:0] code);
		longint unsigned v;
		longint unsigned hi;
		longint unsigned lo;
		v = 64'd260000000 + 64'(code) * 64'd26855;
		if (v >= CURVE_MV[0] * 64'd100000) return 7'd100;
		if (v <= CURVE_MV[10] * 64'd100000) return 7'd0;
		for (int i = 0; i < 10; i++) begin
			hi = CURVE_MV[i] * 64'd100000;
			lo = CURVE_MV[i + 1] * 64'd100000;
			if (v <= hi && v > lo)
				return 7'(64'(90 - 10 * i) + (v - lo) * 64'd10 / (hi - lo));
		end
		return 7'd0;
	endfunction

	function automatic gauge_reading_t gauge_reading_of(poll_t p);
		gauge_reading_t r;
		longint unsigned mag;
		longint unsigned q;
		logic [2:0] chg;
		chg = p.status_byte[7:5];
		r.vbat_mv = mv_q8({p.vbat_hi[5:0], p.vbat_lo});
		r.ocv_mv = mv_q8({p.ocv_hi[5:0], p.ocv_lo});
		if (p.cur_hi[5]) mag = 64'({~p.cur_hi[4:0], ~p.cur_lo}) + 64'd1;
		else mag = 64'({p.cur_hi[4:0], p.cur_lo});
		q = mag * 64'd190972160 / 64'd1000000;
		r.cur = p.cur_hi[5] ? 22'(-q) : 22'(q);
		r.pct = (chg == full_code) ? 7'd100 : ocv_percent({p.ocv_hi[5:0], p.ocv_lo});
		r.led = btg_pkg::LED_NONE;
		if (p.vbus && {1'b0, chg} != last_state) begin
			r.led = (chg == full_code) ? btg_pkg::LED_SOLID : btg_pkg::LED_BLINK;
			last_state = {1'b0, chg};
		end
		return r;
	endfunction

	function automatic logic [13:0] ocv_code_at(int mv);
		longint unsigned num;
		num = 64'(mv - 2600) * 64'd100000;
		return 14'((num + 64'd26854) / 64'd26855);
	endfunction

	function automatic int idle_len(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic note_field(string name, longint want, longint got);
		if (want != got) begin
			errors++;
			$display("%0t %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	task automatic push_poll(logic [13:0] vbat, logic [7:0] vbat_pad, logic [13:0] ocv,
			logic [7:0] ocv_pad, logic [7:0] cur_lo, logic [7:0] cur_hi,
			logic [7:0] status_byte, logic vbus);
		poll_t p;
		p.vbat_lo = vbat[7:0];
		p.vbat_hi = {vbat_pad[7:6], vbat[13:8]};
		p.ocv_lo = ocv[7:0];
		p.ocv_hi = {ocv_pad[7:6], ocv[13:8]};
		p.cur_lo = cur_lo;
		p.cur_hi = cur_hi;
		p.status_byte = status_byte;
		p.vbus = vbus;
		polls_to_send.push_back(p);
	endtask

	task automatic push_random_polls(int count);
		logic [13:0] ocv;
		logic [2:0] chg;
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 65) ocv = 14'($urandom_range(2150, 5850));
			else if (r < 85) ocv = ocv_code_at(int'(CURVE_MV[$urandom_range(0, 10)]))
				+ 14'($urandom_range(0, 4)) - 14'd2;
			else ocv = 14'($urandom);
			r = $urandom_range(0, 99);
			if (r < 30) chg = full_code;
			else if (r < 55) chg = prev_rand_state;
			else chg = 3'($urandom);
			prev_rand_state = chg;
			push_poll(14'($urandom), 8'($urandom), ocv, 8'($urandom), 8'($urandom),
				8'($urandom), {chg, 5'($urandom)}, $urandom_range(0, 99) < 70);
		end
	endtask

	task automatic drain_and_settle();
		do @(negedge clk);
		while (polls_to_send.size() != 0 || s_axis_tvalid || gauge_readings.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_full_code(logic [2:0] code);
		cfg_valid <= 1'b1;
		cfg_data <= code;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				gauge_readings.push_back(gauge_reading_of(poll_t'(s_axis_tdata[56:0])));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (polls_to_send.size() != 0) begin
					s_axis_tdata <= {7'd0, polls_to_send.pop_front()};
					s_axis_tvalid <= 1'b1;
					if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
					send_gap = idle_len(send_calm);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		gauge_reading_t got;
		gauge_reading_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[72:0];
				if (gauge_readings.size() == 0) begin
					errors++;
					$display("%0t unexpected item: expected none actual %h", $time, m_axis_tdata);
				end else begin
					want = gauge_readings.pop_front();
					note_field("battery_mv_q8", want.vbat_mv, got.vbat_mv);
					note_field("open_circuit_mv_q8", want.ocv_mv, got.ocv_mv);
					note_field("current_ma_q8", want.cur, got.cur);
					note_field("charge_percent", want.pct, got.pct);
					note_field("led_event", want.led, got.led);
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
				recv_stall = idle_len(recv_calm);
			end
		end
	end

	always @(posedge clk) begin
		if (cfg_valid && cfg_ready) full_code = cfg_data;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t watchdog: no item moved for %0d cycles", $time, idle_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full code still at its reset value, state 5
		push_poll(14'd0, 8'h00, 14'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
		push_poll(14'd0, 8'h00, 14'd0, 8'h00, 8'h00, 8'h00, 8'h1F, 1'b1);
		push_poll(14'h3FFF, 8'h00, 14'h3FFF, 8'h00, 8'hFF, 8'h1F, 8'hA0, 1'b1);
		push_poll(14'h3FFF, 8'hC0, 14'd0, 8'hC0, 8'h00, 8'h20, 8'hBF, 1'b0);
		push_poll(14'h1234, 8'h40, 14'd3000, 8'h80, 8'hFF, 8'h3F, 8'h60, 1'b0);
		push_poll(14'h0ABC, 8'h80, 14'd4000, 8'h00, 8'hFF, 8'hFF, 8'h60, 1'b1);
		push_poll(14'd1, 8'h00, ocv_code_at(4150), 8'h00, 8'h01, 8'hC0, 8'h60, 1'b1);
		push_poll(14'd2, 8'h00, ocv_code_at(4150) - 14'd1, 8'h00, 8'h00, 8'hE0, 8'h7F, 1'b1);
		push_poll(14'd3, 8'h00, ocv_code_at(3200), 8'h00, 8'h80, 8'h20, 8'h60, 1'b1);
		push_poll(14'd4, 8'h00, ocv_code_at(3200) - 14'd1, 8'h00, 8'h7F, 8'h10, 8'h60, 1'b1);
		push_poll(14'd5, 8'h00, ocv_code_at(3680), 8'h00, 8'h55, 8'h0A, 8'hE0, 1'b1);
		push_poll(14'd6, 8'h00, ocv_code_at(3680) - 14'd1, 8'h00, 8'hAA, 8'h35, 8'hE0, 1'b1);
		push_poll(14'd7, 8'h00, 14'd0, 8'h00, 8'h00, 8'h00, 8'hA0, 1'b1);
		push_poll(14'd8, 8'h00, 14'h3FFF, 8'h00, 8'h00, 8'h00, 8'h20, 1'b0);
		drain_and_settle();

		write_full_code(3'd0);
		push_random_polls(PHASE_POLLS);
		drain_and_settle();
		write_full_code(3'd7);
		push_random_polls(PHASE_POLLS);
		drain_and_settle();
		write_full_code(3'd2);
		push_random_polls(PHASE_POLLS);
		drain_and_settle();
		write_full_code(btg_pkg::FULL_CODE_RESET);
		push_random_polls(PHASE_POLLS);
		drain_and_settle();

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/btg_pkg.sv
src/btg_ctrl.sv
src/btg_dp.sv
src/battery_telemetry_gauge.sv
dv/tb_battery_telemetry_gauge.sv
